// ===== hw/rtl/dense_graph_shortest_paths_unit_assert.svh =====
// Assertion macros for the shortest path unit checker.
`ifndef DENSE_GRAPH_SHORTEST_PATHS_UNIT_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATHS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DGSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DGSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dgsp_pkg.sv =====
package dgsp_pkg;

    localparam int NODE_FIELD_W = 4;
    localparam int IN_WEIGHT_W  = 8;
    localparam int COST_W       = 12;
    localparam int KEY_W        = COST_W + 1;
    localparam int SUM_W        = COST_W + 1;

    localparam logic [COST_W-1:0] COST_MAX      = '1;
    localparam logic [KEY_W-1:0]  UNREACHED_KEY = KEY_W'(1) << COST_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_LSB = 2;
    localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_SOURCE = '0;

    typedef struct packed {
        logic                    opcode;
        logic [NODE_FIELD_W-1:0] row_node;
        logic [NODE_FIELD_W-1:0] col_node;
        logic [IN_WEIGHT_W-1:0]  edge_weight;
    } t_in_item;

    typedef struct packed {
        logic [NODE_FIELD_W-1:0] node_index;
        logic [COST_W-1:0]       distance;
        logic                    reachable;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic clear_en;
        logic wr_en;
        logic run_init;
        logic scan_issue;
        logic settle;
        logic relax_issue;
    } t_dp_cmd;

    typedef struct packed {
        logic sel_unreached;
    } t_dp_status;

endpackage

// ===== hw/rtl/dense_graph_shortest_paths_unit.sv =====
// Single-source shortest paths over a dense weighted adjacency matrix.
// Input channel (i_in_valid/o_in_ready): a write item (opcode 0) stores one
// edge weight, zero meaning no edge; a run item (opcode 1) searches from the
// source node held in the APB register at address 0.
// Output channel (o_out_valid/i_out_ready): a run yields NODES items, one per
// node in index order, with last set on node NODES-1. A write yields none.
// After reset the weight store is swept to zero with o_in_ready low; APB
// writes are taken during the sweep.
// A write item leaves the block idle and ready. A run takes NODES-1 rounds:
// a scan over the cost store, a pick step and a settle step, then a relax
// pass over the picked node's weight row unless that node is unreached.
// Each store has a single read port that walks one node per cycle.
// Results then follow one at a time, each read out before it is shown.
// A stalled receiver holds the current result item; the block takes no new
// input item until the last result of the run is taken.
module dense_graph_shortest_paths_unit #(
    parameter int NODES       = 16,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dgsp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dgsp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dgsp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dgsp_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dgsp_pkg::t_out_item                 o_out_item
);

    import dgsp_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int AW = $clog2(NODES * NODES);

    logic [NODE_FIELD_W-1:0] r_source;
    logic                    reg_hit;
    t_dp_cmd                 cmd;
    t_dp_status              status;
    logic [NW-1:0]           k;
    logic [AW-1:0]           clr_addr;

    assign reg_hit = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_SOURCE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DATA_W'(r_source) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source <= '0;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_source <= pwdata[NODE_FIELD_W-1:0];
        end
    end

    dgsp_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_item.opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status),
        .o_k         (k),
        .o_clr_addr  (clr_addr)
    );

    dgsp_datapath #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_k        (k),
        .i_clr_addr (clr_addr),
        .i_in_item  (i_in_item),
        .i_source   (r_source),
        .o_out_item (o_out_item)
    );

endmodule

// ===== hw/rtl/dgsp_ram.sv =====
module dgsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/dgsp_ctrl.sv =====
module dgsp_ctrl #(
    parameter int NODES = 16,
    localparam int NW = $clog2(NODES),
    localparam int AW = $clog2(NODES * NODES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_opcode,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dgsp_pkg::t_dp_cmd    o_cmd,
    input  dgsp_pkg::t_dp_status i_status,
    output logic [NW-1:0]        o_k,
    output logic [AW-1:0]        o_clr_addr
);

    import dgsp_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_PICK   = 4'd3;
    localparam logic [3:0] S_SETTLE = 4'd4;
    localparam logic [3:0] S_RELAX  = 4'd5;
    localparam logic [3:0] S_RFLUSH = 4'd6;
    localparam logic [3:0] S_OREAD  = 4'd7;
    localparam logic [3:0] S_OSHOW  = 4'd8;

    localparam logic [NW-1:0] K_LAST     = NW'(NODES - 1);
    localparam logic [NW-1:0] ROUND_LAST = NW'(NODES - 2);
    localparam logic [AW-1:0] CLR_LAST   = AW'(NODES * NODES - 1);

    logic [3:0]    r_state, n_state;
    logic [NW-1:0] r_k, n_k;
    logic [NW-1:0] r_round, n_round;
    logic [AW-1:0] r_clr, n_clr;
    t_dp_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_round = r_round;
        n_clr   = r_clr;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_RUN) begin
                        cmd.run_init = 1'b1;
                        n_state      = S_SCAN;
                        n_k          = '0;
                        n_round      = '0;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (r_k == K_LAST) begin
                    n_state = S_PICK;
                    n_k     = '0;
                end else begin
                    n_k = r_k + NW'(1);
                end
            end
            S_PICK: begin
                n_state = S_SETTLE;
            end
            S_SETTLE: begin
                cmd.settle = 1'b1;
                n_k        = '0;
                if (!i_status.sel_unreached) begin
                    n_state = S_RELAX;
                end else if (r_round == ROUND_LAST) begin
                    n_state = S_OREAD;
                end else begin
                    n_round = r_round + NW'(1);
                    n_state = S_SCAN;
                end
            end
            S_RELAX: begin
                cmd.relax_issue = 1'b1;
                if (r_k == K_LAST) begin
                    n_state = S_RFLUSH;
                    n_k     = '0;
                end else begin
                    n_k = r_k + NW'(1);
                end
            end
            S_RFLUSH: begin
                n_k = '0;
                if (r_round == ROUND_LAST) begin
                    n_state = S_OREAD;
                end else begin
                    n_round = r_round + NW'(1);
                    n_state = S_SCAN;
                end
            end
            S_OREAD: begin
                n_state = S_OSHOW;
            end
            S_OSHOW: begin
                if (i_out_ready) begin
                    if (r_k == K_LAST) begin
                        n_state = S_IDLE;
                        n_k     = '0;
                    end else begin
                        n_k     = r_k + NW'(1);
                        n_state = S_OREAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_round <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_round <= n_round;
            r_clr   <= n_clr;
        end
    end

    assign o_cmd       = cmd;
    assign o_k         = r_k;
    assign o_clr_addr  = r_clr;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OSHOW);

endmodule

// ===== hw/rtl/dgsp_datapath.sv =====
module dgsp_datapath #(
    parameter int NODES       = 16,
    parameter int WEIGHT_BITS = 8,
    localparam int NW = $clog2(NODES),
    localparam int AW = $clog2(NODES * NODES)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dgsp_pkg::t_dp_cmd                   i_cmd,
    output dgsp_pkg::t_dp_status                o_status,
    input  logic [NW-1:0]                       i_k,
    input  logic [AW-1:0]                       i_clr_addr,
    input  dgsp_pkg::t_in_item                  i_in_item,
    input  logic [dgsp_pkg::NODE_FIELD_W-1:0]   i_source,
    output dgsp_pkg::t_out_item                 o_out_item
);

    import dgsp_pkg::*;

    localparam int WSW = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
    localparam logic [NW-1:0] K_LAST = NW'(NODES - 1);

    logic [NODES-1:0]  r_unreached;
    logic [NODES-1:0]  r_settled;
    logic              r_scan_v;
    logic              r_relax_v;
    logic [NW-1:0]     r_kd;
    logic [KEY_W-1:0]  r_best;
    logic [NW-1:0]     r_sel;
    logic [AW-1:0]     r_base;
    logic [COST_W-1:0] r_cost_m;

    logic              row_ok, col_ok, source_ok;
    logic [NW-1:0]     src_idx;
    logic [AW-1:0]     in_waddr;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [WSW-1:0]    w_wr_data;
    logic [AW-1:0]     w_rd_addr;
    logic [WSW-1:0]    w_rd_data;
    logic              c_wr_en;
    logic [NW-1:0]     c_wr_addr;
    logic [COST_W-1:0] c_wr_data;
    logic [COST_W-1:0] c_rd_data;
    logic [SUM_W-1:0]  sum;
    logic [COST_W-1:0] new_cost;
    logic              relax_hit;
    logic [KEY_W-1:0]  key;
    logic              take;
    logic [NODES-1:0]  unreached_init;

    assign row_ok    = 32'(i_in_item.row_node) < NODES;
    assign col_ok    = 32'(i_in_item.col_node) < NODES;
    assign source_ok = 32'(i_source) < NODES;
    assign src_idx   = NW'(i_source);
    assign in_waddr  = AW'(i_in_item.row_node) * AW'(NODES) + AW'(i_in_item.col_node);

    assign w_wr_en   = i_cmd.clear_en | (i_cmd.wr_en & row_ok & col_ok);
    assign w_wr_addr = i_cmd.clear_en ? i_clr_addr : in_waddr;
    assign w_wr_data = i_cmd.clear_en ? '0 : WSW'(i_in_item.edge_weight);
    assign w_rd_addr = r_base + AW'(i_k);

    dgsp_ram #(
        .WIDTH (WSW),
        .DEPTH (NODES * NODES)
    ) u_weight_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign sum       = SUM_W'(r_cost_m) + SUM_W'(w_rd_data);
    assign new_cost  = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
    assign relax_hit = r_relax_v & ~r_settled[r_kd] & (w_rd_data != '0)
                     & (r_unreached[r_kd] | (sum < SUM_W'(c_rd_data)));

    assign c_wr_en   = (i_cmd.run_init & source_ok) | relax_hit;
    assign c_wr_addr = i_cmd.run_init ? src_idx : r_kd;
    assign c_wr_data = i_cmd.run_init ? '0 : new_cost;

    dgsp_ram #(
        .WIDTH (COST_W),
        .DEPTH (NODES)
    ) u_cost_ram (
        .i_clk     (i_clk),
        .i_wr_en   (c_wr_en),
        .i_wr_addr (c_wr_addr),
        .i_wr_data (c_wr_data),
        .i_rd_addr (i_k),
        .o_rd_data (c_rd_data)
    );

    assign key  = r_unreached[r_kd] ? UNREACHED_KEY : {1'b0, c_rd_data};
    assign take = r_scan_v & ~r_settled[r_kd] & (key <= r_best);

    always_comb begin
        unreached_init = '1;
        if (source_ok) begin
            unreached_init[src_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_v    <= 1'b0;
            r_relax_v   <= 1'b0;
            r_unreached <= '1;
            r_settled   <= '0;
        end else begin
            r_scan_v  <= i_cmd.scan_issue;
            r_relax_v <= i_cmd.relax_issue;
            if (i_cmd.run_init) begin
                r_unreached <= unreached_init;
                r_settled   <= '0;
            end else begin
                if (i_cmd.settle) begin
                    r_settled[r_sel] <= 1'b1;
                end
                if (relax_hit) begin
                    r_unreached[r_kd] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kd <= i_k;
        if (i_cmd.scan_issue && i_k == '0) begin
            r_best <= UNREACHED_KEY;
            r_sel  <= '0;
        end else if (take) begin
            r_best <= key;
            r_sel  <= r_kd;
        end
        if (i_cmd.settle) begin
            r_base   <= AW'(r_sel) * AW'(NODES);
            r_cost_m <= r_best[COST_W-1:0];
        end
    end

    assign o_status.sel_unreached = r_unreached[r_sel];

    assign o_out_item.node_index = NODE_FIELD_W'(i_k);
    assign o_out_item.distance   = r_unreached[i_k] ? '0 : c_rd_data;
    assign o_out_item.reachable  = ~r_unreached[i_k];
    assign o_out_item.last       = (i_k == K_LAST);

endmodule

// ===== hw/rtl/dgsp_checker.sv =====
`include "dense_graph_shortest_paths_unit_assert.svh"

module dgsp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input dgsp_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dgsp_pkg::t_out_item o_out_item
);

    import dgsp_pkg::*;

    `DGSP_ASSERT_NOW(a_busy_excl, o_out_valid, !o_in_ready, "result shown while taking items")

    `DGSP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "stalled result item changed")

    `DGSP_ASSERT_NEXT(a_run_busy, i_in_valid && o_in_ready && i_in_item.opcode == OP_RUN, !o_in_ready, "run item did not block input")

    `DGSP_ASSERT_NEXT(a_write_ready, i_in_valid && o_in_ready && i_in_item.opcode == OP_WRITE, o_in_ready && !o_out_valid, "write item stalled input or made a result")

    `DGSP_ASSERT_NEXT(a_last_idle, o_out_valid && i_out_ready && o_out_item.last, o_in_ready && !o_out_valid, "block not idle after last result")

endmodule

bind dense_graph_shortest_paths_unit dgsp_checker u_dgsp_checker (.*);

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dgsp_pkg::*;

    localparam int N_NODES     = 16;
    localparam int WEIGHT_BITS = 8;
    localparam int DIR_LEN     = 21;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 28;
    localparam int HOLD_PHASE  = 3;
    localparam int HOLD_CYCLES = 1500;
    localparam int MAX_PRINTS  = 100;
    localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_SPARE = 1'b1;

    typedef struct packed {
        t_in_item           item;
        logic               typed;
        logic [N_NODES-1:0] reach;
        logic [COST_W-1:0]  far_cost;
    } t_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;

    logic [IN_WEIGHT_W-1:0]  edge_wts [N_NODES][N_NODES];
    logic [NODE_FIELD_W-1:0] src_node;
    t_out_item               dist_queue [$];
    t_step                   dir_table [DIR_LEN];
    int                      err_count;
    int                      burst_left;
    bit                      hold_arm;
    bit                      hold_used;
    int                      hold_left;
    int                      rx_tick;
    int                      rx_mode;

    dense_graph_shortest_paths_unit #(
        .NODES       (N_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("tb: mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    function automatic t_step mk(input logic op, input int row, input int col, input int w,
                                 input logic typed = 1'b0,
                                 input logic [N_NODES-1:0] reach = '0,
                                 input int far = 0);
        t_step s;
        s.item.opcode      = op;
        s.item.row_node    = NODE_FIELD_W'(row);
        s.item.col_node    = NODE_FIELD_W'(col);
        s.item.edge_weight = IN_WEIGHT_W'(w);
        s.typed            = typed;
        s.reach            = reach;
        s.far_cost         = COST_W'(far);
        return s;
    endfunction

    function automatic t_step rand_step(input bit force_run);
        int   pick;
        int   w;
        logic op;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            w = 0;
        end else if (pick < 5) begin
            w = $urandom_range(1, 15);
        end else if (pick == 5) begin
            w = $urandom_range(240, 255);
        end else begin
            w = $urandom_range(0, 255);
        end
        op = (force_run || $urandom_range(0, 99) < 18) ? OP_RUN : OP_WRITE;
        return mk(op, $urandom_range(0, 15), $urandom_range(0, 15), w);
    endfunction

    function automatic logic [APB_ADDR_W-1:0] reg_addr(input int idx);
        return APB_ADDR_W'(idx << REG_IDX_LSB);
    endfunction

    function automatic void push_dist(input int k, input logic reach,
                                      input logic [COST_W-1:0] cost);
        t_out_item r;
        r.node_index = NODE_FIELD_W'(k);
        r.distance   = reach ? cost : '0;
        r.reachable  = reach;
        r.last       = (k == N_NODES - 1);
        dist_queue.push_back(r);
    endfunction

    function automatic void predict_search();
        logic [COST_W-1:0] cost [N_NODES];
        bit                unreached [N_NODES];
        bit                settled [N_NODES];
        logic [KEY_W-1:0]  best;
        logic [KEY_W-1:0]  key;
        logic [SUM_W-1:0]  sum;
        int                pick;
        for (int k = 0; k < N_NODES; k++) begin
            cost[k]      = '0;
            unreached[k] = 1'b1;
            settled[k]   = 1'b0;
        end
        if (int'(src_node) < N_NODES) begin
            unreached[src_node] = 1'b0;
        end
        for (int r = 0; r < N_NODES - 1; r++) begin
            best = UNREACHED_KEY;
            pick = 0;
            for (int k = 0; k < N_NODES; k++) begin
                key = unreached[k] ? UNREACHED_KEY : KEY_W'(cost[k]);
                if (!settled[k] && key <= best) begin
                    best = key;
                    pick = k;
                end
            end
            settled[pick] = 1'b1;
            if (!unreached[pick]) begin
                for (int k = 0; k < N_NODES; k++) begin
                    if (!settled[k] && edge_wts[pick][k] != '0) begin
                        sum = SUM_W'(cost[pick]) + SUM_W'(edge_wts[pick][k]);
                        if (unreached[k] || sum < SUM_W'(cost[k])) begin
                            cost[k]      = (sum > SUM_W'(COST_MAX)) ? COST_MAX
                                                                    : sum[COST_W-1:0];
                            unreached[k] = 1'b0;
                        end
                    end
                end
            end
        end
        for (int k = 0; k < N_NODES; k++) begin
            push_dist(k, !unreached[k], cost[k]);
        end
    endfunction

    function automatic void record_item(input t_step s);
        if (s.item.opcode == OP_WRITE) begin
            if (int'(s.item.row_node) < N_NODES && int'(s.item.col_node) < N_NODES) begin
                edge_wts[s.item.row_node][s.item.col_node] = s.item.edge_weight;
            end
        end else if (s.typed) begin
            for (int k = 0; k < N_NODES; k++) begin
                push_dist(k, s.reach[k], (k == int'(src_node)) ? '0 : s.far_cost);
            end
        end else begin
            predict_search();
        end
    endfunction

    task automatic send_item(input t_step s);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= s.item;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        record_item(s);
    endtask

    task automatic quiesce(input int tail);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (dist_queue.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_source(input logic [NODE_FIELD_W-1:0] node);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b1, reg_addr(int'(REG_SOURCE)), APB_DATA_W'(node), rd);
        src_node = node;
        apb_xfer(1'b0, reg_addr(int'(REG_SOURCE)), '0, rd);
        if (rd[NODE_FIELD_W-1:0] !== node) begin
            flag_mismatch($sformatf("source_node read %0d want %0d",
                                    rd[NODE_FIELD_W-1:0], node));
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_arm && !hold_used && o_out_valid === 1'b1) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_tick == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_tick = $urandom_range(16, 96);
            end
            rx_tick--;
            case (rx_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (dist_queue.size() == 0) begin
                flag_mismatch($sformatf("unexpected item for node %0d",
                                        o_out_item.node_index));
            end else begin
                want = dist_queue.pop_front();
                if (o_out_item.node_index !== want.node_index) begin
                    flag_mismatch($sformatf("node_index got %0d want %0d",
                                            o_out_item.node_index, want.node_index));
                end
                if (o_out_item.distance !== want.distance) begin
                    flag_mismatch($sformatf("node %0d distance got %0d want %0d",
                                            want.node_index, o_out_item.distance,
                                            want.distance));
                end
                if (o_out_item.reachable !== want.reachable) begin
                    flag_mismatch($sformatf("node %0d reachable got %b want %b",
                                            want.node_index, o_out_item.reachable,
                                            want.reachable));
                end
                if (o_out_item.last !== want.last) begin
                    flag_mismatch($sformatf("node %0d last got %b want %b",
                                            want.node_index, o_out_item.last, want.last));
                end
            end
        end
    end

    initial begin : stimulus
        logic [APB_DATA_W-1:0] rd;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        err_count   = 0;
        burst_left  = 0;
        hold_arm    = 1'b0;
        hold_used   = 1'b0;
        hold_left   = 0;
        rx_tick     = 0;
        rx_mode     = 0;
        src_node    = '0;
        for (int r = 0; r < N_NODES; r++) begin
            for (int c = 0; c < N_NODES; c++) begin
                edge_wts[r][c] = '0;
            end
        end

        dir_table = '{
            mk(OP_RUN,    0,  0,   0, 1'b1, 16'h0001, 0),
            mk(OP_WRITE,  0, 15, 255),
            mk(OP_RUN,   15, 15, 255, 1'b1, 16'h8001, 255),
            mk(OP_WRITE,  0, 15,   0),
            mk(OP_RUN,   10,  5, 170, 1'b1, 16'h0001, 0),
            mk(OP_WRITE,  0,  3,   5),
            mk(OP_WRITE,  0,  7,   5),
            mk(OP_WRITE,  7,  9,   1),
            mk(OP_WRITE,  3,  9,   1),
            mk(OP_WRITE,  3,  0,   1),
            mk(OP_WRITE,  5,  5, 200),
            mk(OP_WRITE, 15, 14, 128),
            mk(OP_WRITE,  0,  1,   1),
            mk(OP_WRITE,  1,  2,   1),
            mk(OP_WRITE,  0,  2,  10),
            mk(OP_WRITE,  2, 15, 254),
            mk(OP_WRITE, 15, 15, 255),
            mk(OP_RUN,    0,  0,   0),
            mk(OP_WRITE,  0,  3,   0),
            mk(OP_WRITE, 12, 11,  85),
            mk(OP_RUN,    5, 10,  85)
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_LEN; i++) begin
            send_item(dir_table[i]);
        end
        quiesce(8);

        set_source(NODE_FIELD_W'(N_NODES - 1));
        send_item(mk(OP_RUN, 0, 0, 0));
        quiesce(8);

        set_source('0);
        apb_xfer(1'b1, reg_addr(int'(REG_SPARE)), APB_DATA_W'(N_NODES - 1), rd);
        send_item(mk(OP_RUN, 15, 15, 255));
        quiesce(8);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                set_source(NODE_FIELD_W'(N_NODES - 1));
            end else if (p == 1) begin
                set_source('0);
            end else begin
                set_source(NODE_FIELD_W'($urandom_range(0, N_NODES - 1)));
            end
            if (p == HOLD_PHASE) begin
                hold_arm = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(rand_step(p == HOLD_PHASE && n == 0));
            end
            quiesce(8);
        end

        quiesce(64);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
